// ===== rtl/lts_pkg.sv =====
// Shared constants, codes and controller/datapath interface structs for the
// layered topological sort unit. No dependencies.
package lts_pkg;

	localparam int NODE_MAX   = 256;
	localparam int EDGE_DEPTH = 1024;
	localparam int NODE_W     = 8;
	localparam int CNT_W      = 9;
	localparam int EIDX_W     = 11;
	localparam int EADDR_W    = 10;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SORT  = 3'd1;
	localparam logic [2:0] OP_QNODE = 3'd2;
	localparam logic [2:0] OP_QPRED = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_DUP    = 3'd2;
	localparam logic [2:0] ST_UNPL   = 3'd3;
	localparam logic [2:0] ST_SOURCE = 3'd4;
	localparam logic [2:0] ST_SLOT   = 3'd5;
	localparam logic [2:0] ST_BAD    = 3'd6;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_BAD,
		RES_ADD,
		RES_SORT,
		RES_NODE,
		RES_PRED
	} res_sel_t;

	typedef struct packed {
		logic     cap;
		logic     eidx_clr;
		logic     eidx_inc;
		logic     edge_rd;
		logic     edge_wr;
		logic     clr_all;
		logic     dup_clr;
		logic     dup_chk;
		logic     vidx_clr;
		logic     vidx_inc;
		logic     pend_clr_wr;
		logic     pend_rd;
		logic     pend_rd_to;
		logic     pend_inc_wr;
		logic     pend_dec_wr;
		logic     placed_clr;
		logic     tail_clr;
		logic     push;
		logic     push_to;
		logic     head_clr;
		logic     q_rd;
		logic     lay_clr;
		logic     lay_inc;
		logic     lay_open;
		logic     place;
		logic     deg_clr;
		logic     deg_chk;
		logic     lp_rd;
		logic     lp_pred;
		logic     res_we;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       a_bad;
		logic       b_bad;
		logic       eidx_end;
		logic       vidx_last;
		logic       vidx_end;
		logic       head_eq_tail;
		logic       head_eq_end;
		logic       cnt_hit;
		logic       walk_hit;
		logic       pend_zero;
		logic       pend_one;
	} sts_t;

endpackage

// ===== rtl/layered_topological_sort_unit.sv =====
// Top level of the layered topological sort unit.
// Instantiates lts_ctrl and lts_dp; depends on lts_pkg.
//
// channel  ports                                   handshake
// request  op, node_a, node_b, pred_slot           start & !busy
// result   status, layer, position, count          done, one cycle
// config   cfg_wdata                               cfg_we
//
// Add edge and query each scan all loaded edges, one edge memory read per
// step. Clear, bad node and unknown op answer straight from decode.
// Sort: clear all 256 pending entries, count in-edges over the edge list,
// scan the active nodes for sources, then layer by layer place each queued
// task and walk the edge list. Reset is asynchronous; memories need no clearing pass.
// The result is shown for one cycle and cannot be stalled.
module layered_topological_sort_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] op,
	input  logic [7:0] node_a,
	input  logic [7:0] node_b,
	input  logic [7:0] pred_slot,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	output logic       done,
	output logic [2:0] status,
	output logic [7:0] layer,
	output logic [7:0] position,
	output logic [8:0] count
);

	lts_pkg::cmd_t cmd;
	lts_pkg::sts_t sts;

	lts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.node_a    (node_a),
		.node_b    (node_b),
		.pred_slot (pred_slot),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.status    (status),
		.layer     (layer),
		.position  (position),
		.count     (count)
	);

endmodule

// ===== rtl/lts_ctrl.sv =====
// Sequencing state machine for the layered topological sort unit.
// Depends on lts_pkg for op codes and the command/status structs.
module lts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lts_pkg::sts_t sts,
	output lts_pkg::cmd_t cmd,
	output logic          busy
);

	typedef enum logic [4:0] {
		S_IDLE, S_DEC,
		S_ADD_RD, S_ADD_EV, S_ADD_FIN,
		S_CLR, S_CNT_RD, S_CNT_EV, S_CNT_WR,
		S_SRC_RD, S_SRC_EV,
		S_LAY, S_T_RD, S_T_EV, S_W_RD, S_W_EV, S_W_WR, S_SORT_FIN,
		S_Q_RD, S_Q_EV, S_Q_FIN, S_Q_RES
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				priority if (sts.op == lts_pkg::OP_ADD) begin
					if (sts.a_bad || sts.b_bad) begin
						cmd.res_we  = 1'b1;
						cmd.res_sel = lts_pkg::RES_BAD;
					end else begin
						cmd.eidx_clr = 1'b1;
						cmd.dup_clr  = 1'b1;
						state_d      = S_ADD_RD;
					end
				end else if (sts.op == lts_pkg::OP_SORT) begin
					cmd.vidx_clr   = 1'b1;
					cmd.placed_clr = 1'b1;
					state_d        = S_CLR;
				end else if (sts.op == lts_pkg::OP_QNODE || sts.op == lts_pkg::OP_QPRED) begin
					if (sts.a_bad) begin
						cmd.res_we  = 1'b1;
						cmd.res_sel = lts_pkg::RES_BAD;
					end else begin
						cmd.eidx_clr = 1'b1;
						cmd.deg_clr  = 1'b1;
						state_d      = S_Q_RD;
					end
				end else if (sts.op == lts_pkg::OP_CLEAR) begin
					cmd.clr_all = 1'b1;
					cmd.res_we  = 1'b1;
					cmd.res_sel = lts_pkg::RES_ZERO;
				end else begin
					cmd.res_we  = 1'b1;
					cmd.res_sel = lts_pkg::RES_ZERO;
				end
			end
			S_ADD_RD: begin
				if (sts.eidx_end) begin
					state_d = S_ADD_FIN;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = S_ADD_EV;
				end
			end
			S_ADD_EV: begin
				cmd.dup_chk  = 1'b1;
				cmd.eidx_inc = 1'b1;
				state_d      = S_ADD_RD;
			end
			S_ADD_FIN: begin
				cmd.edge_wr = 1'b1;
				cmd.res_we  = 1'b1;
				cmd.res_sel = lts_pkg::RES_ADD;
				state_d     = S_IDLE;
			end
			S_CLR: begin
				cmd.pend_clr_wr = 1'b1;
				cmd.vidx_inc    = 1'b1;
				if (sts.vidx_last) begin
					cmd.eidx_clr = 1'b1;
					state_d      = S_CNT_RD;
				end
			end
			S_CNT_RD: begin
				if (sts.eidx_end) begin
					cmd.vidx_clr = 1'b1;
					cmd.tail_clr = 1'b1;
					state_d      = S_SRC_RD;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = S_CNT_EV;
				end
			end
			S_CNT_EV: begin
				if (sts.cnt_hit) begin
					cmd.pend_rd    = 1'b1;
					cmd.pend_rd_to = 1'b1;
					state_d        = S_CNT_WR;
				end else begin
					cmd.eidx_inc = 1'b1;
					state_d      = S_CNT_RD;
				end
			end
			S_CNT_WR: begin
				cmd.pend_inc_wr = 1'b1;
				cmd.eidx_inc    = 1'b1;
				state_d         = S_CNT_RD;
			end
			S_SRC_RD: begin
				if (sts.vidx_end) begin
					cmd.head_clr = 1'b1;
					cmd.lay_clr  = 1'b1;
					state_d      = S_LAY;
				end else begin
					cmd.pend_rd = 1'b1;
					state_d     = S_SRC_EV;
				end
			end
			S_SRC_EV: begin
				cmd.push     = sts.pend_zero;
				cmd.vidx_inc = 1'b1;
				state_d      = S_SRC_RD;
			end
			S_LAY: begin
				if (sts.head_eq_tail) begin
					state_d = S_SORT_FIN;
				end else begin
					cmd.lay_open = 1'b1;
					state_d      = S_T_RD;
				end
			end
			S_T_RD: begin
				if (sts.head_eq_end) begin
					cmd.lay_inc = 1'b1;
					state_d     = S_LAY;
				end else begin
					cmd.q_rd = 1'b1;
					state_d  = S_T_EV;
				end
			end
			S_T_EV: begin
				cmd.place    = 1'b1;
				cmd.eidx_clr = 1'b1;
				state_d      = S_W_RD;
			end
			S_W_RD: begin
				if (sts.eidx_end) begin
					state_d = S_T_RD;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = S_W_EV;
				end
			end
			S_W_EV: begin
				if (sts.walk_hit) begin
					cmd.pend_rd    = 1'b1;
					cmd.pend_rd_to = 1'b1;
					state_d        = S_W_WR;
				end else begin
					cmd.eidx_inc = 1'b1;
					state_d      = S_W_RD;
				end
			end
			S_W_WR: begin
				cmd.pend_dec_wr = !sts.pend_zero;
				cmd.push        = sts.pend_one;
				cmd.push_to     = 1'b1;
				cmd.eidx_inc    = 1'b1;
				state_d         = S_W_RD;
			end
			S_SORT_FIN: begin
				cmd.res_we  = 1'b1;
				cmd.res_sel = lts_pkg::RES_SORT;
				state_d     = S_IDLE;
			end
			S_Q_RD: begin
				if (sts.eidx_end) begin
					state_d = S_Q_FIN;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = S_Q_EV;
				end
			end
			S_Q_EV: begin
				cmd.deg_chk  = 1'b1;
				cmd.eidx_inc = 1'b1;
				state_d      = S_Q_RD;
			end
			S_Q_FIN: begin
				cmd.lp_rd   = 1'b1;
				cmd.lp_pred = (sts.op == lts_pkg::OP_QPRED);
				state_d     = S_Q_RES;
			end
			S_Q_RES: begin
				cmd.res_we  = 1'b1;
				cmd.res_sel = (sts.op == lts_pkg::OP_QPRED) ? lts_pkg::RES_PRED
					: lts_pkg::RES_NODE;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lts_dp.sv =====
// Datapath of the layered topological sort unit: edge, pending, queue and
// placement memories, counters and result registers. Depends on lts_pkg.
module lts_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  lts_pkg::cmd_t cmd,
	output lts_pkg::sts_t sts,
	input  logic [2:0]    op,
	input  logic [7:0]    node_a,
	input  logic [7:0]    node_b,
	input  logic [7:0]    pred_slot,
	input  logic          cfg_we,
	input  logic [8:0]    cfg_wdata,
	output logic          done,
	output logic [2:0]    status,
	output logic [7:0]    layer,
	output logic [7:0]    position,
	output logic [8:0]    count
);

	logic [15:0] edge_mem [lts_pkg::EDGE_DEPTH];
	logic [8:0]  pend_mem [lts_pkg::NODE_MAX];
	logic [7:0]  q_mem    [lts_pkg::NODE_MAX];
	logic [15:0] lp_mem   [lts_pkg::NODE_MAX];

	logic [2:0]  op_q;
	logic [7:0]  a_q, b_q, slot_q, pred_q, pos_q;
	logic [8:0]  node_count_q, n;
	logic [10:0] edges_q, eidx_q;
	logic [15:0] edge_rd_q, lp_rd_q;
	logic [8:0]  pend_rd_q;
	logic [7:0]  t_q;
	logic [8:0]  vidx_q, head_q, tail_q, end_q, lay_q, deg_q;
	logic        dup_q, found_q;
	logic [lts_pkg::NODE_MAX-1:0] placed_q;
	logic [7:0]  e_from, e_to, pend_addr, pend_waddr;
	logic [8:0]  pend_wdata;
	logic        pend_we, e_from_ok, e_to_ok, to_hit;
	logic        edge_store;
	logic        done_q;
	logic [2:0]  status_q;
	logic [7:0]  layer_q, position_q;
	logic [8:0]  count_q;

	assign e_from    = edge_rd_q[15:8];
	assign e_to      = edge_rd_q[7:0];
	assign e_from_ok = ({1'b0, e_from} < n);
	assign e_to_ok   = ({1'b0, e_to} < n);
	assign to_hit    = (e_to == a_q) && e_from_ok;

	assign edge_store = cmd.edge_wr && !dup_q && !edges_q[10];

	always_comb begin
		priority if (node_count_q == 9'd0) begin
			n = 9'd1;
		end else if (node_count_q > 9'(lts_pkg::NODE_MAX)) begin
			n = 9'(lts_pkg::NODE_MAX);
		end else begin
			n = node_count_q;
		end
	end

	assign sts.op           = op_q;
	assign sts.a_bad        = ({1'b0, a_q} >= n);
	assign sts.b_bad        = ({1'b0, b_q} >= n);
	assign sts.eidx_end     = (eidx_q == edges_q);
	assign sts.vidx_last    = (vidx_q[7:0] == 8'hFF);
	assign sts.vidx_end     = (vidx_q == n);
	assign sts.head_eq_tail = (head_q == tail_q);
	assign sts.head_eq_end  = (head_q == end_q);
	assign sts.cnt_hit      = e_from_ok && e_to_ok;
	assign sts.walk_hit     = (e_from == t_q) && e_to_ok;
	assign sts.pend_zero    = (pend_rd_q == 9'd0);
	assign sts.pend_one     = (pend_rd_q == 9'd1);

	assign pend_addr  = cmd.pend_rd_to ? e_to : vidx_q[7:0];
	assign pend_we    = cmd.pend_clr_wr || cmd.pend_inc_wr || cmd.pend_dec_wr;
	assign pend_waddr = cmd.pend_clr_wr ? vidx_q[7:0] : e_to;

	always_comb begin
		priority if (cmd.pend_clr_wr) begin
			pend_wdata = 9'd0;
		end else if (cmd.pend_inc_wr) begin
			pend_wdata = pend_rd_q + 9'd1;
		end else begin
			pend_wdata = pend_rd_q - 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_store) begin
			edge_mem[edges_q[lts_pkg::EADDR_W-1:0]] <= {a_q, b_q};
		end
		if (cmd.edge_rd) begin
			edge_rd_q <= edge_mem[eidx_q[lts_pkg::EADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[pend_waddr] <= pend_wdata;
		end
		if (cmd.pend_rd) begin
			pend_rd_q <= pend_mem[pend_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !tail_q[8]) begin
			q_mem[tail_q[7:0]] <= cmd.push_to ? e_to : vidx_q[7:0];
		end
		if (cmd.q_rd) begin
			t_q <= q_mem[head_q[7:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.place) begin
			lp_mem[t_q] <= {lay_q[7:0], pos_q};
		end
		if (cmd.lp_rd) begin
			lp_rd_q <= lp_mem[cmd.lp_pred ? pred_q : a_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= op;
			a_q    <= node_a;
			b_q    <= node_b;
			slot_q <= pred_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 9'(lts_pkg::NODE_MAX);
			edges_q      <= '0;
			eidx_q       <= '0;
			vidx_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			end_q        <= '0;
			lay_q        <= '0;
			pos_q        <= '0;
			deg_q        <= '0;
			pred_q       <= '0;
			dup_q        <= 1'b0;
			found_q      <= 1'b0;
			placed_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.res_we;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (cmd.clr_all) begin
				edges_q <= '0;
			end else if (edge_store) begin
				edges_q <= edges_q + 11'd1;
			end
			if (cmd.eidx_clr) begin
				eidx_q <= '0;
			end else if (cmd.eidx_inc) begin
				eidx_q <= eidx_q + 11'd1;
			end
			if (cmd.vidx_clr) begin
				vidx_q <= '0;
			end else if (cmd.vidx_inc) begin
				vidx_q <= vidx_q + 9'd1;
			end
			if (cmd.dup_clr) begin
				dup_q <= 1'b0;
			end else if (cmd.dup_chk && e_from == a_q && e_to == b_q) begin
				dup_q <= 1'b1;
			end
			if (cmd.deg_clr) begin
				deg_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.deg_chk && to_hit) begin
				deg_q <= deg_q + 9'd1;
				if (!found_q && deg_q == {1'b0, slot_q}) begin
					found_q <= 1'b1;
					pred_q  <= e_from;
				end
			end
			if (cmd.tail_clr) begin
				tail_q <= '0;
			end else if (cmd.push && !tail_q[8]) begin
				tail_q <= tail_q + 9'd1;
			end
			if (cmd.head_clr) begin
				head_q <= '0;
			end else if (cmd.q_rd) begin
				head_q <= head_q + 9'd1;
			end
			if (cmd.lay_clr) begin
				lay_q <= '0;
			end else if (cmd.lay_inc) begin
				lay_q <= lay_q + 9'd1;
			end
			if (cmd.lay_open) begin
				end_q <= tail_q;
				pos_q <= '0;
			end else if (cmd.place) begin
				pos_q <= pos_q + 8'd1;
			end
			if (cmd.clr_all || cmd.placed_clr) begin
				placed_q <= '0;
			end else if (cmd.place) begin
				placed_q[t_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			status_q   <= lts_pkg::ST_OK;
			layer_q    <= '0;
			position_q <= '0;
			count_q    <= '0;
			unique case (cmd.res_sel)
				lts_pkg::RES_ZERO: begin
				end
				lts_pkg::RES_BAD: begin
					status_q <= lts_pkg::ST_BAD;
				end
				lts_pkg::RES_ADD: begin
					if (dup_q) begin
						status_q <= lts_pkg::ST_DUP;
					end else if (edges_q[10]) begin
						status_q <= lts_pkg::ST_FULL;
					end
				end
				lts_pkg::RES_SORT: begin
					status_q <= (tail_q == n) ? lts_pkg::ST_OK : lts_pkg::ST_UNPL;
					count_q  <= lay_q;
				end
				lts_pkg::RES_NODE: begin
					count_q <= deg_q;
					if (placed_q[a_q]) begin
						layer_q    <= lp_rd_q[15:8];
						position_q <= lp_rd_q[7:0];
					end else begin
						status_q <= lts_pkg::ST_UNPL;
					end
				end
				lts_pkg::RES_PRED: begin
					priority if (deg_q == 9'd0) begin
						status_q <= lts_pkg::ST_SOURCE;
					end else if (!found_q) begin
						status_q <= lts_pkg::ST_SLOT;
					end else if (!placed_q[pred_q]) begin
						status_q <= lts_pkg::ST_UNPL;
					end else begin
						layer_q    <= lp_rd_q[15:8];
						position_q <= lp_rd_q[7:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign layer    = layer_q;
	assign position = position_q;
	assign count    = count_q;

endmodule

// ===== bench/layered_topological_sort_unit_test.sv =====
// Self-checking bench for the layered topological sort unit: drives edge loads,
// sorts, queries and clears against a built-in dependency graph predictor.
// Depends on lts_pkg and layered_topological_sort_unit.
`timescale 1ns / 100ps

module layered_topological_sort_unit_test;

	localparam logic [2:0] OP_UNUSED = 3'd5;
	localparam int CYCLE_LIMIT = 20000000;

	typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN} kind_t;

	typedef struct {
		kind_t      kind;
		logic [2:0] op;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] slot;
		logic [8:0] value;
	} job_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] layer;
		logic [7:0] position;
		logic [8:0] count;
	} answer_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       start = 0;
	logic       busy;
	logic [2:0] op = 0;
	logic [7:0] node_a = 0, node_b = 0, pred_slot = 0;
	logic       cfg_we = 0;
	logic [8:0] cfg_wdata = 0;
	logic       done;
	logic [2:0] status;
	logic [7:0] layer, position;
	logic [8:0] count;

	layered_topological_sort_unit dut (.*);

	always #5 clk = ~clk;

	job_t    pending[$];
	answer_t expected[$];
	int      errors = 0;
	int      cycles = 0;
	int      gen_edges = 0;

	// graph model
	logic [7:0] efrom[lts_pkg::EDGE_DEPTH];
	logic [7:0] eto[lts_pkg::EDGE_DEPTH];
	int         eload = 0;
	bit         placed[lts_pkg::NODE_MAX];
	int         tlay[lts_pkg::NODE_MAX];
	int         tpos[lts_pkg::NODE_MAX];
	logic [8:0] ncfg = 9'd256;

	function automatic int nodes_active();
		if (ncfg == 0) return 1;
		if (ncfg > lts_pkg::NODE_MAX) return lts_pkg::NODE_MAX;
		return ncfg;
	endfunction

	function automatic int nodes_active_of(logic [8:0] v);
		if (v == 0) return 1;
		if (v > lts_pkg::NODE_MAX) return lts_pkg::NODE_MAX;
		return v;
	endfunction

	function automatic int indeg(int v, int n);
		int d = 0;
		for (int e = 0; e < eload; e++)
			if (eto[e] == v && efrom[e] < n) d++;
		return d;
	endfunction

	function automatic answer_t predict_graph(logic [2:0] o, int a, int b, int s);
		answer_t r;
		int n, seen, pred, head, tail, lay, stop, pos, t, to;
		int pend[lts_pkg::NODE_MAX];
		int rq[lts_pkg::NODE_MAX];
		bit dup, found;
		r = '0;
		n = nodes_active();
		case (o)
			lts_pkg::OP_ADD: begin
				if (a >= n || b >= n) r.status = lts_pkg::ST_BAD;
				else begin
					dup = 0;
					for (int e = 0; e < eload; e++)
						if (efrom[e] == a && eto[e] == b) dup = 1;
					if (dup) r.status = lts_pkg::ST_DUP;
					else if (eload >= lts_pkg::EDGE_DEPTH) r.status = lts_pkg::ST_FULL;
					else begin
						efrom[eload] = 8'(a);
						eto[eload] = 8'(b);
						eload++;
					end
				end
			end
			lts_pkg::OP_SORT: begin
				head = 0;
				tail = 0;
				lay = 0;
				for (int v = 0; v < lts_pkg::NODE_MAX; v++) begin
					placed[v] = 0;
					pend[v] = 0;
				end
				for (int e = 0; e < eload; e++)
					if (efrom[e] < n && eto[e] < n) pend[eto[e]]++;
				for (int v = 0; v < n; v++)
					if (pend[v] == 0) rq[tail++] = v;
				while (head < tail) begin
					stop = tail;
					pos = 0;
					while (head < stop) begin
						t = rq[head++];
						tlay[t] = lay;
						tpos[t] = pos++;
						placed[t] = 1;
						for (int e = 0; e < eload; e++) begin
							to = eto[e];
							if (efrom[e] == t && to < n && pend[to] != 0) begin
								pend[to]--;
								if (pend[to] == 0 && tail < lts_pkg::NODE_MAX)
									rq[tail++] = to;
							end
						end
					end
					lay++;
				end
				r.status = (tail == n) ? lts_pkg::ST_OK : lts_pkg::ST_UNPL;
				r.count = 9'(lay);
			end
			lts_pkg::OP_QNODE: begin
				if (a >= n) r.status = lts_pkg::ST_BAD;
				else begin
					r.count = 9'(indeg(a, n));
					if (placed[a]) begin
						r.layer = 8'(tlay[a]);
						r.position = 8'(tpos[a]);
					end else r.status = lts_pkg::ST_UNPL;
				end
			end
			lts_pkg::OP_QPRED: begin
				if (a >= n) r.status = lts_pkg::ST_BAD;
				else if (indeg(a, n) == 0) r.status = lts_pkg::ST_SOURCE;
				else begin
					seen = 0;
					pred = 0;
					found = 0;
					for (int e = 0; e < eload && !found; e++)
						if (eto[e] == a && efrom[e] < n) begin
							if (seen == s) begin
								pred = efrom[e];
								found = 1;
							end
							seen++;
						end
					if (!found) r.status = lts_pkg::ST_SLOT;
					else if (!placed[pred]) r.status = lts_pkg::ST_UNPL;
					else begin
						r.layer = 8'(tlay[pred]);
						r.position = 8'(tpos[pred]);
					end
				end
			end
			lts_pkg::OP_CLEAR: begin
				eload = 0;
				for (int v = 0; v < lts_pkg::NODE_MAX; v++) placed[v] = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic push_req(logic [2:0] o, int a, int b = 0, int s = 0);
		job_t j;
		j.kind = K_REQ;
		j.op = o;
		j.a = 8'(a);
		j.b = 8'(b);
		j.slot = 8'(s);
		j.value = 0;
		pending = {pending, j};
		if (o == lts_pkg::OP_ADD) gen_edges++;
		if (o == lts_pkg::OP_CLEAR) gen_edges = 0;
	endtask

	task automatic push_cfg(int v);
		job_t j;
		j = '{K_DRAIN, 0, 0, 0, 0, 0};
		pending = {pending, j};
		j.kind = K_CFG;
		j.value = 9'(v);
		pending = {pending, j};
	endtask

	// driver
	int gap = 0;
	int quiet = 0;
	always @(posedge clk) begin
		logic nstart;
		logic nwe;
		job_t j;
		nstart = start;
		nwe = 0;
		cycles <= cycles + 1;
		if (start && !busy) begin
			expected = {expected, predict_graph(op, node_a, node_b, pred_slot)};
			nstart = 0;
			case ($urandom_range(0, 19))
				0: gap = $urandom_range(10, 40);
				1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
				default: gap = 0;
			endcase
		end
		if (expected.size() == 0 && !start) quiet++;
		else quiet = 0;
		if (arst_n && !nstart && pending.size() != 0) begin
			if (gap > 0) gap--;
			else begin
				j = pending[0];
				if (j.kind == K_REQ) begin
					op <= j.op;
					node_a <= j.a;
					node_b <= j.b;
					pred_slot <= j.slot;
					nstart = 1;
					void'(pending.pop_front());
				end else if (quiet >= 8) begin
					if (j.kind == K_CFG) begin
						nwe = 1;
						cfg_wdata <= j.value;
						ncfg = j.value;
					end
					void'(pending.pop_front());
				end
			end
		end
		cfg_we <= nwe;
		start <= nstart;
	end

	// monitor
	always @(posedge clk) begin
		answer_t w;
		if (done) begin
			if (expected.size() == 0) begin
				$display("%0t unexpected result st=%0d lay=%0d pos=%0d cnt=%0d",
					$time, status, layer, position, count);
				errors++;
			end else begin
				w = expected.pop_front();
				if (status !== w.status) begin
					$display("%0t status exp %0d got %0d", $time, w.status, status);
					errors++;
				end
				if (layer !== w.layer) begin
					$display("%0t layer exp %0d got %0d", $time, w.layer, layer);
					errors++;
				end
				if (position !== w.position) begin
					$display("%0t position exp %0d got %0d", $time, w.position, position);
					errors++;
				end
				if (count !== w.count) begin
					$display("%0t count exp %0d got %0d", $time, w.count, count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end

	function automatic int pick_nodes();
		case ($urandom_range(0, 19))
			0: return $urandom_range(0, 1);
			1: return 256;
			2: return $urandom_range(257, 511);
			3, 4: return $urandom_range(17, 64);
			default: return $urandom_range(2, 16);
		endcase
	endfunction

	function automatic int pick_node(int n);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
		return $urandom_range(0, n - 1);
	endfunction

	function automatic int pick_slot();
		if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
		return $urandom_range(0, 3);
	endfunction

	initial begin
		int n, x, y, reqs;
		// directed
		push_req(lts_pkg::OP_QNODE, 0);
		push_req(lts_pkg::OP_QPRED, 0);
		push_req(lts_pkg::OP_ADD, 0, 1);
		push_req(lts_pkg::OP_ADD, 0, 1);
		push_req(lts_pkg::OP_ADD, 255, 0);
		push_req(lts_pkg::OP_ADD, 1, 1);
		for (int k = OP_UNUSED; k <= 7; k++) push_req(3'(k), 255, 255, 255);
		push_req(lts_pkg::OP_SORT, 0);
		push_req(lts_pkg::OP_QNODE, 255);
		push_req(lts_pkg::OP_QPRED, 0, 0, 0);
		push_req(lts_pkg::OP_QPRED, 0, 0, 9);
		push_req(lts_pkg::OP_QPRED, 1, 0, 1);
		push_req(lts_pkg::OP_CLEAR, 0);
		push_req(lts_pkg::OP_SORT, 0);
		push_cfg(0);
		push_req(lts_pkg::OP_ADD, 0, 1);
		push_req(lts_pkg::OP_QNODE, 1);
		push_req(lts_pkg::OP_QPRED, 255);
		push_req(lts_pkg::OP_ADD, 0, 0);
		push_req(lts_pkg::OP_SORT, 0);
		push_cfg(3);
		push_req(lts_pkg::OP_ADD, 0, 2);
		push_req(lts_pkg::OP_ADD, 2, 1);
		push_cfg(2);
		push_req(lts_pkg::OP_SORT, 0);
		push_req(lts_pkg::OP_QPRED, 1, 0, 0);
		push_cfg(511);
		push_req(lts_pkg::OP_SORT, 0);
		// load a dense edge block
		push_cfg(33);
		push_req(lts_pkg::OP_CLEAR, 0);
		for (int i = 0; i < 8; i++)
			for (int k = 0; k < 16; k++) push_req(lts_pkg::OP_ADD, i, k);
		push_req(lts_pkg::OP_ADD, 32, 0);
		push_req(lts_pkg::OP_ADD, 3, 3);
		push_req(lts_pkg::OP_QPRED, 0, 0, 40);
		push_req(lts_pkg::OP_SORT, 0);
		push_req(lts_pkg::OP_CLEAR, 0);
		// random phases
		reqs = 0;
		while (reqs < 600) begin
			push_cfg(pick_nodes());
			n = nodes_active_of(pending[pending.size() - 1].value);
			if (gen_edges > 60 || $urandom_range(0, 1)) push_req(lts_pkg::OP_CLEAR, 0);
			repeat ($urandom_range(0, (n > 40) ? 12 : 25)) begin
				x = $urandom_range(0, n - 1);
				y = $urandom_range(0, n - 1);
				if ($urandom_range(0, 6) == 0)
					push_req(lts_pkg::OP_ADD, pick_node(n), pick_node(n));
				else if (x < y) push_req(lts_pkg::OP_ADD, x, y);
				else if (x > y) push_req(lts_pkg::OP_ADD, y, x);
				else push_req(lts_pkg::OP_ADD, x, (x + 1) % n);
				reqs++;
			end
			push_req(lts_pkg::OP_SORT, 0);
			repeat ($urandom_range(3, 10)) begin
				push_req($urandom_range(0, 1) ? lts_pkg::OP_QNODE : lts_pkg::OP_QPRED,
					pick_node(n), 0, pick_slot());
				reqs++;
			end
			if ($urandom_range(0, 3) == 0) begin
				push_req(lts_pkg::OP_ADD, pick_node(n), pick_node(n));
				push_req(lts_pkg::OP_QNODE, pick_node(n));
				push_req(lts_pkg::OP_QPRED, pick_node(n), 0, pick_slot());
				push_req(3'($urandom_range(OP_UNUSED, 7)), $urandom_range(0, 255));
				reqs += 4;
			end
			reqs += 2;
		end
		push_cfg(256);
		push_req(lts_pkg::OP_QNODE, 255);

		repeat (9) @(posedge clk);
		arst_n <= 1;
		wait (pending.size() == 0 && !start && expected.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
